// ===== rtl/core/ida_pkg.sv =====
// Shared types, constants and helpers for the slot id allocator.
package ida_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int ID_W      = 10;          // slot id / result_id width
  localparam int CNT_W     = ID_W + 1;    // occupancy count and stack fill
  localparam int MODE_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_CLAIM    = 2'd1,
    MODE_OVERRIDE = 2'd2,
    MODE_FREE     = 2'd3
  } ida_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,   // occupancy bit of cand_r is on the map read port
    S_POP,    // popped recycled id is on the stack read port
    S_RESP    // result ready, waiting for the output register
  } ida_state_t;

  // Occupancy map access, one read and one write per cycle.
  typedef struct packed {
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic            wr_bit;
  } ida_map_req_t;

  // Circular successor of an id.
  function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    if (v == ID_W'(POOL_SIZE - 1)) r = '0;
    else                           r = v + 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/ida_map.sv =====
// Occupancy bit memory with a clearing sweep after reset.
module ida_map (
  input  logic                clk,
  input  logic                rst_n,
  input  ida_pkg::ida_map_req_t req,
  output logic                rd_bit,
  output logic                busy
);

  logic                      occ_mem [ida_pkg::POOL_SIZE];
  logic                      rd_q_r;
  logic                      busy_r;
  logic [ida_pkg::ID_W-1:0]  clr_cnt_r;

  // clear sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ida_pkg::ID_W'(ida_pkg::POOL_SIZE - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      occ_mem[clr_cnt_r] <= 1'b0;
    end else if (req.wr_en) begin
      occ_mem[req.wr_addr] <= req.wr_bit;
    end
    rd_q_r <= occ_mem[req.rd_addr];
  end

  assign rd_bit = rd_q_r;
  assign busy   = busy_r;

endmodule

// ===== rtl/core/id_allocator_with_recycle_stack_top.sv =====
// Top level of the slot id allocator: sequencer, recycle stack and handshakes.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | to block  | in_valid/in_stall | in_mode, in_slot_id
//  out_    | from block| out_valid/out_stall| out_ok, out_result_id, out_replaced,
//          |           |                   | out_live_count
//
//  Claim and free: map read at the transfer, then update and respond steps; the next transfer
//  waits until the request is back in idle. Allocate: also pops recycled ids and steps the
//  circular scan before it takes a slot; a full pool goes straight to the respond step.
//  After reset the occupancy map is swept clear, with in_stall held high.
//  in_stall is high whenever a request is in flight; a result held in the output
//  register does not block the next transfer, that request then waits in its respond step.
module id_allocator_with_recycle_stack_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ida_pkg::MODE_W-1:0] in_mode,
  input  logic [ida_pkg::ID_W-1:0]   in_slot_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ok,
  output logic [ida_pkg::ID_W-1:0]   out_result_id,
  output logic                       out_replaced,
  output logic [ida_pkg::CNT_W-1:0]  out_live_count
);

  ida_pkg::ida_state_t      state_r, state_nxt;
  ida_pkg::ida_mode_t       mode_r, mode_nxt;
  logic [ida_pkg::ID_W-1:0]  cand_r, cand_nxt;     // id under test
  logic [ida_pkg::ID_W-1:0]  np_r, np_nxt;         // next pointer
  logic [ida_pkg::CNT_W-1:0] count_r, count_nxt;   // occupied slots
  logic [ida_pkg::CNT_W-1:0] fill_r, fill_nxt;     // recycle stack depth
  logic                      res_ok_r, res_ok_nxt;
  logic [ida_pkg::ID_W-1:0]  res_id_r, res_id_nxt;
  logic                      res_repl_r, res_repl_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic [ida_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic                      out_repl_r, out_repl_nxt;
  logic [ida_pkg::CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  ida_pkg::ida_map_req_t     map_req;
  logic                      occ;
  logic                      map_busy;

  // recycle stack
  logic [ida_pkg::ID_W-1:0]  stk_mem [ida_pkg::POOL_SIZE];
  logic [ida_pkg::ID_W-1:0]  stk_q_r;
  logic [ida_pkg::ID_W-1:0]  stk_raddr;
  logic                      stk_we;
  logic [ida_pkg::CNT_W-1:0] fill_dec;

  logic                      in_xfer;
  logic                      out_free;
  logic                      pool_full;
  logic                      id_bad;
  logic                      stk_room;
  logic [ida_pkg::ID_W-1:0]  np_take;   // next pointer after taking cand_r
  logic [ida_pkg::ID_W-1:0]  np_step;   // next pointer one scan step on

  ida_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (map_req),
    .rd_bit (occ),
    .busy   (map_busy)
  );

  assign in_stall  = (state_r != ida_pkg::S_IDLE) || map_busy;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pool_full = count_r >= ida_pkg::CNT_W'(ida_pkg::POOL_SIZE);
  assign id_bad    = {1'b0, in_slot_id} >= ida_pkg::CNT_W'(ida_pkg::POOL_SIZE);
  assign stk_room  = fill_r < ida_pkg::CNT_W'(ida_pkg::POOL_SIZE);
  assign fill_dec  = fill_r - 1'b1;
  assign stk_raddr = fill_dec[ida_pkg::ID_W-1:0];
  assign np_step   = ida_pkg::wrap_inc(np_r);
  assign np_take   = (cand_r == np_r) ? np_step : np_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ida_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_mode == ida_pkg::MODE_ALLOC) begin
            state_nxt = pool_full ? ida_pkg::S_RESP : ida_pkg::S_LOOK;
          end else begin
            state_nxt = id_bad ? ida_pkg::S_RESP : ida_pkg::S_LOOK;
          end
        end
      end
      ida_pkg::S_LOOK: begin
        if (mode_r == ida_pkg::MODE_ALLOC && occ) begin
          state_nxt = (fill_r != '0) ? ida_pkg::S_POP : ida_pkg::S_LOOK;
        end else begin
          state_nxt = ida_pkg::S_RESP;
        end
      end
      ida_pkg::S_POP:  state_nxt = ida_pkg::S_LOOK;
      ida_pkg::S_RESP: if (out_free) state_nxt = ida_pkg::S_IDLE;
      default:         state_nxt = ida_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mode_nxt      = mode_r;
    cand_nxt      = cand_r;
    np_nxt        = np_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    res_repl_nxt  = res_repl_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;
    out_repl_nxt  = out_repl_r;
    out_cnt_nxt   = out_cnt_r;
    map_req.wr_en   = 1'b0;
    map_req.wr_addr = cand_r;
    map_req.wr_bit  = 1'b1;
    stk_we        = 1'b0;

    unique case (state_r)
      ida_pkg::S_IDLE: begin
        if (in_xfer) begin
          mode_nxt     = ida_pkg::ida_mode_t'(in_mode);
          res_ok_nxt   = 1'b0;
          res_id_nxt   = '0;
          res_repl_nxt = 1'b0;
          cand_nxt     = (in_mode == ida_pkg::MODE_ALLOC) ? np_r : in_slot_id;
        end
      end
      ida_pkg::S_LOOK: begin
        unique case (mode_r)
          ida_pkg::MODE_ALLOC: begin
            if (!occ) begin
              map_req.wr_en = 1'b1;
              count_nxt     = count_r + 1'b1;
              np_nxt        = np_take;
              res_ok_nxt    = 1'b1;
              res_id_nxt    = cand_r;
            end else if (fill_r != '0) begin
              fill_nxt = fill_dec;
            end else begin
              // circular scan step
              np_nxt   = np_step;
              cand_nxt = np_step;
            end
          end
          ida_pkg::MODE_FREE: begin
            if (occ) begin
              map_req.wr_en  = 1'b1;
              map_req.wr_bit = 1'b0;
              count_nxt      = count_r - 1'b1;
              stk_we         = stk_room;
              if (stk_room) fill_nxt = fill_r + 1'b1;
              res_ok_nxt     = 1'b1;
              res_id_nxt     = cand_r;
            end
          end
          ida_pkg::MODE_CLAIM, ida_pkg::MODE_OVERRIDE: begin
            if (!occ) begin
              map_req.wr_en = 1'b1;
              count_nxt     = count_r + 1'b1;
              np_nxt        = np_take;
              res_ok_nxt    = 1'b1;
              res_id_nxt    = cand_r;
            end else if (mode_r == ida_pkg::MODE_OVERRIDE) begin
              // release then take again: bit and count unchanged, id pushed if the stack has room
              stk_we       = stk_room;
              if (stk_room) fill_nxt = fill_r + 1'b1;
              np_nxt       = np_take;
              res_ok_nxt   = 1'b1;
              res_id_nxt   = cand_r;
              res_repl_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ida_pkg::S_POP: begin
        cand_nxt = stk_q_r;
      end
      ida_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_id_nxt    = res_id_r;
          out_repl_nxt  = res_repl_r;
          out_cnt_nxt   = count_r;
        end
      end
      default: ;
    endcase

    map_req.rd_addr = cand_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ida_pkg::S_IDLE;
      np_r        <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      np_r        <= np_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cand_r     <= cand_nxt;
    res_ok_r   <= res_ok_nxt;
    res_id_r   <= res_id_nxt;
    res_repl_r <= res_repl_nxt;
    out_ok_r   <= out_ok_nxt;
    out_id_r   <= out_id_nxt;
    out_repl_r <= out_repl_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[fill_r[ida_pkg::ID_W-1:0]] <= cand_r;
    stk_q_r <= stk_mem[stk_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_result_id  = out_id_r;
  assign out_replaced   = out_repl_r;
  assign out_live_count = out_cnt_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ida_pkg::CNT_W'(ida_pkg::POOL_SIZE))
    else $error("occupied count beyond pool size");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ida_pkg::CNT_W'(ida_pkg::POOL_SIZE))
    else $error("recycle stack overfilled");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ida_pkg::S_LOOK && state_nxt == ida_pkg::S_POP) |=>
      (fill_r == $past(fill_r) - 1'b1))
    else $error("pop did not lower the stack fill");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ida_pkg::S_RESP))
    else $error("result presented outside the respond step");

  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    map_busy |-> (state_r == ida_pkg::S_IDLE && !out_valid_r))
    else $error("activity during occupancy map clear");

endmodule

// ===== dv/tb_id_allocator_with_recycle_stack_top.sv =====
// Self-checking testbench for the slot id allocator: predicted responses vs. DUT results.
`timescale 1ns / 1ps

module tb_id_allocator_with_recycle_stack_top;
  import ida_pkg::*;

  // One response as the block presents it on the out_ channel.
  typedef struct packed {
    logic             ok;
    logic [ID_W-1:0]  id;
    logic             replaced;
    logic [CNT_W-1:0] live;
  } alloc_result_t;

  // Scoreboard: shadow of the pool state plus the queue of responses still owed.
  class slot_pool_scoreboard;
    bit               occupied[POOL_SIZE];
    logic [CNT_W-1:0] live;
    logic [ID_W-1:0]  next_id;
    logic [ID_W-1:0]  recycled[POOL_SIZE];
    logic [CNT_W-1:0] fill;
    alloc_result_t    awaited[$];
    int               errors;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      live    = '0;
      next_id = '0;
      fill    = '0;
      errors  = 0;
    endfunction

    function logic [ID_W-1:0] step_id(input logic [ID_W-1:0] v);
      return ID_W'((int'(v) + 1) % POOL_SIZE);
    endfunction

    function void take_id(input logic [ID_W-1:0] id);
      if (id == next_id) next_id = step_id(next_id);
      occupied[id] = 1'b1;
      live = live + 1'b1;
    endfunction

    // freed ids go on the recycle stack; a push onto a full stack is lost
    function void release_id(input logic [ID_W-1:0] id);
      occupied[id] = 1'b0;
      live = live - 1'b1;
      if (fill < POOL_SIZE) begin
        recycled[fill] = id;
        fill = fill + 1'b1;
      end
    endfunction

    // Predict the response to one accepted request, queue it, and return it.
    function alloc_result_t note_request(input ida_mode_t m, input logic [ID_W-1:0] id);
      alloc_result_t r;
      logic [ID_W-1:0] cand;
      int n;
      r = '0;
      if (m == MODE_ALLOC) begin
        if (live < POOL_SIZE) begin
          cand = next_id;
          // pop until a free recycled id shows up; stale ones are dropped
          while (occupied[cand] && fill != 0) begin
            fill = fill - 1'b1;
            cand = recycled[fill];
          end
          // then walk the pointer round the pool
          for (n = 0; occupied[cand] && n < POOL_SIZE; n++) begin
            next_id = step_id(next_id);
            cand = next_id;
          end
          if (!occupied[cand]) begin
            take_id(cand);
            r.ok = 1'b1;
            r.id = cand;
          end
        end
      end else if (int'(id) < POOL_SIZE) begin
        if (m == MODE_FREE) begin
          if (occupied[id]) begin
            release_id(id);
            r.ok = 1'b1;
            r.id = id;
          end
        end else begin
          if (occupied[id] && m == MODE_OVERRIDE) begin
            release_id(id);
            r.replaced = 1'b1;
          end
          if (!occupied[id]) begin
            take_id(id);
            r.ok = 1'b1;
            r.id = id;
          end
        end
      end
      r.live = live;
      awaited = {awaited, r};
      return r;
    endfunction

    function void check_response(input logic ok, input logic [ID_W-1:0] id,
                                 input logic replaced, input logic [CNT_W-1:0] cnt);
      alloc_result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result ok=%0d id=%0d replaced=%0d live=%0d",
                   $time, ok, id, replaced, cnt);
        return;
      end
      exp = awaited.pop_front();
      if (ok !== exp.ok || id !== exp.id || replaced !== exp.replaced || cnt !== exp.live) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: mismatch exp ok=%0d id=%0d replaced=%0d live=%0d",
                 $time, exp.ok, exp.id, exp.replaced, exp.live);
          $display(" | got ok=%0d id=%0d replaced=%0d live=%0d", ok, id, replaced, cnt);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ida_mode_t         in_mode = MODE_ALLOC;
  logic [ID_W-1:0]   in_slot_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_ok;
  logic [ID_W-1:0]   out_result_id;
  logic              out_replaced;
  logic [CNT_W-1:0]  out_live_count;

  slot_pool_scoreboard sb;

  // Percent chance per cycle that each side idles; changed between phases.
  int send_idle_pct = 21;
  int recv_idle_pct = 70;

  // Ring of ids handed out lately, used to aim claims/frees/overrides at live slots.
  logic [ID_W-1:0] recent_ids[16];
  int              recent_wr = 0;

  id_allocator_with_recycle_stack_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_slot_id    (in_slot_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_result_id (out_result_id),
    .out_replaced  (out_replaced),
    .out_live_count(out_live_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: a transfer happens at an edge with out_valid high and out_stall low.
  // Both are read before this edge's updates land, so the check sees settled values.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_response(out_ok, out_result_id, out_replaced, out_live_count);
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Drive one request and hold it until the transfer; then predict its response.
  // in_valid is only lowered for an idle gap, so it is never dropped and raised
  // again within one time step.
  task automatic issue(input ida_mode_t m, input logic [ID_W-1:0] id);
    alloc_result_t res;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_slot_id <= id;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = sb.note_request(m, id);
    if (res.ok && m != MODE_FREE) begin
      recent_ids[recent_wr] = res.id;
      recent_wr = (recent_wr + 1) % 16;
    end
  endtask

  // Hold the input side quiet until every predicted response has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Ids biased toward the interesting places: just ahead of the next pointer
  // (forces pointer collisions and the scan), recently issued ids, the top of
  // the recycle stack, and anywhere in the pool.
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sb.next_id + ID_W'($urandom_range(0, 7));
      4, 5:       return recent_ids[$urandom_range(0, 15)];
      6:          return (sb.fill != 0) ? sb.recycled[sb.fill - 1'b1]
                                        : ID_W'($urandom_range(0, POOL_SIZE - 1));
      default:    return ID_W'($urandom_range(0, POOL_SIZE - 1));
    endcase
  endfunction

  task automatic random_mixed(input int count);
    int sel;
    ida_mode_t m;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)      m = MODE_ALLOC;
      else if (sel < 55) m = MODE_CLAIM;
      else if (sel < 75) m = MODE_OVERRIDE;
      else               m = MODE_FREE;
      issue(m, pick_id());
    end
  endtask

  initial begin
    foreach (recent_ids[i]) recent_ids[i] = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // The map clear after reset holds in_stall high; the first transfer waits it out.

    // Directed: refusals, pointer advance, override, stale pops, scan, pop hit.
    issue(MODE_FREE, '0);                        // free of an empty slot
    issue(MODE_ALLOC, ID_W'(POOL_SIZE - 1));     // slot_id ignored, takes 0
    issue(MODE_ALLOC, '0);
    issue(MODE_CLAIM, ID_W'(POOL_SIZE - 1));     // top id
    issue(MODE_CLAIM, ID_W'(POOL_SIZE - 1));     // occupied, no override
    issue(MODE_OVERRIDE, ID_W'(POOL_SIZE - 1));  // freed, pushed, retaken
    issue(MODE_FREE, ID_W'(POOL_SIZE - 1));
    issue(MODE_CLAIM, ID_W'(2));                 // claim at the pointer
    issue(MODE_CLAIM, ID_W'(3));
    issue(MODE_CLAIM, ID_W'(5));                 // blocks the slot after the pointer
    issue(MODE_ALLOC, '0);                       // takes 4, pointer lands on 5
    issue(MODE_CLAIM, ID_W'(POOL_SIZE - 1));     // stack now holds only stale ids
    issue(MODE_ALLOC, '0);                       // pops stale twice, then scans
    issue(MODE_FREE, '0);
    issue(MODE_CLAIM, ID_W'(8));
    issue(MODE_ALLOC, '0);
    issue(MODE_ALLOC, '0);                       // pointer busy, popped id is free
    issue(MODE_FREE, ID_W'(POOL_SIZE - 1));
    issue(MODE_OVERRIDE, ID_W'(512));            // override on a free slot
    issue(MODE_CLAIM, ID_W'(10'b1010101010));
    issue(MODE_FREE, ID_W'(10'b0101010101));
    issue(MODE_FREE, ID_W'(10'b1010101010));
    wait_results_drained();

    // Sender idles lightly, receiver heavily.
    random_mixed(75);
    wait_results_drained();

    send_idle_pct = 70;
    recv_idle_pct = 21;
    random_mixed(75);
    wait_results_drained();

    // Full rate: allocate until the pool is full.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sb.live < POOL_SIZE)
      issue(MODE_ALLOC, ID_W'($urandom));
    repeat (4) issue(MODE_OVERRIDE, ID_W'($urandom));  // every slot live, id pushed
    repeat (3) issue(MODE_ALLOC, ID_W'($urandom));     // pool full
    issue(MODE_CLAIM, ID_W'($urandom));                // occupied, refused
    issue(MODE_FREE, ID_W'($urandom));
    issue(MODE_ALLOC, '0);                             // pops the id just freed
    random_mixed(20);

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("id_allocator_with_recycle_stack_top test passed");
    else
      $display("id_allocator_with_recycle_stack_top test failed");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run (every allocate popping and
  // scanning the whole pool, plus every stall and gap).
  initial begin
    #200ms;
    $display("id_allocator_with_recycle_stack_top test failed");
    $finish;
  end

endmodule
